@@ hw/rtl/cfac_pkg.sv @@
// Shared types, constants and helper functions for the clock field adjust controller.
package cfac_pkg;

  typedef enum logic [1:0] {
    MODE_BUTTON  = 2'd0,
    MODE_REFRESH = 2'd1,
    MODE_BLINK   = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    FLD_SEC     = 3'd0,
    FLD_HOUR    = 3'd1,
    FLD_MIN     = 3'd2,
    FLD_WEEKDAY = 3'd3,
    FLD_MONTH   = 3'd4,
    FLD_DATE    = 3'd5,
    FLD_YEAR    = 3'd6
  } field_e;

  localparam logic [15:0] LONG_PRESS_RESET = 16'd1500;
  localparam logic [15:0] HOLD_MAX         = 16'hFFFF;

  localparam logic [6:0] HOUR_MAX    = 7'd23;
  localparam logic [6:0] MIN_MAX     = 7'd59;
  localparam logic [6:0] WEEKDAY_MIN = 7'd1;
  localparam logic [6:0] WEEKDAY_MAX = 7'd7;
  localparam logic [6:0] MONTH_MIN   = 7'd1;
  localparam logic [6:0] MONTH_MAX   = 7'd12;
  localparam logic [6:0] DATE_MIN    = 7'd1;
  localparam logic [6:0] YEAR_MAX    = 7'd99;
  localparam logic [6:0] DAYS_LONG   = 7'd31;
  localparam logic [6:0] DAYS_SHORT  = 7'd30;
  localparam logic [6:0] DAYS_FEB_LP = 7'd29;
  localparam logic [6:0] DAYS_FEB    = 7'd28;

  typedef struct packed {
    mode_e      mode;
    logic       adjust_pressed;
    logic       change_pressed;
    logic [5:0] cur_seconds;
    logic [5:0] cur_minutes;
    logic [4:0] cur_hours;
    logic [2:0] cur_weekday;
    logic [4:0] cur_date;
    logic [3:0] cur_month;
    logic [6:0] cur_year;
  } item_t;

  typedef struct packed {
    logic       write_enable;
    logic [2:0] write_field;
    logic [6:0] write_value;
    logic [2:0] hidden_field;
    logic       adjust_active;
    logic       clear_request;
  } result_t;

  // Advance by one, or wrap to lo once the value reaches hi.
  function automatic logic [6:0] step_wrap(logic [6:0] v, logic [6:0] lo, logic [6:0] hi);
    return (v >= hi) ? lo : v + 7'd1;
  endfunction

  // Month length; anything outside 1..12 counts as a 30 day month.
  function automatic logic [6:0] month_days(logic [3:0] month, logic [6:0] year);
    logic [6:0] days;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = DAYS_LONG;
      4'd2:    days = (year[1:0] == 2'b00) ? DAYS_FEB_LP : DAYS_FEB;
      default: days = DAYS_SHORT;
    endcase
    return days;
  endfunction

endpackage

@@ hw/rtl/cfac_if.sv @@
// Valid/ready channel interfaces for input events and result beats.
interface cfac_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       adjust_pressed;
  logic       change_pressed;
  logic [5:0] cur_seconds;
  logic [5:0] cur_minutes;
  logic [4:0] cur_hours;
  logic [2:0] cur_weekday;
  logic [4:0] cur_date;
  logic [3:0] cur_month;
  logic [6:0] cur_year;

  modport source (
    output valid, mode, adjust_pressed, change_pressed, cur_seconds, cur_minutes,
           cur_hours, cur_weekday, cur_date, cur_month, cur_year,
    input  ready
  );
  modport sink (
    input  valid, mode, adjust_pressed, change_pressed, cur_seconds, cur_minutes,
           cur_hours, cur_weekday, cur_date, cur_month, cur_year,
    output ready
  );
endinterface

interface cfac_result_if;
  logic       valid;
  logic       ready;
  logic       write_enable;
  logic [2:0] write_field;
  logic [6:0] write_value;
  logic [2:0] hidden_field;
  logic       adjust_active;
  logic       clear_request;

  modport source (
    output valid, write_enable, write_field, write_value, hidden_field,
           adjust_active, clear_request,
    input  ready
  );
  modport sink (
    input  valid, write_enable, write_field, write_value, hidden_field,
           adjust_active, clear_request,
    output ready
  );
endinterface

@@ hw/rtl/cfac_wval.sv @@
// Next value for the selected time field, with per-field wrap.
module cfac_wval (
  input  logic [2:0]     field_select_i,
  input  cfac_pkg::item_t item_i,
  output logic [6:0]     write_value_o
);

  always_comb begin
    unique case (cfac_pkg::field_e'(field_select_i))
      cfac_pkg::FLD_SEC:     write_value_o = 7'd0;  // seconds are cleared
      cfac_pkg::FLD_HOUR:    write_value_o = cfac_pkg::step_wrap(
                               7'(item_i.cur_hours), 7'd0, cfac_pkg::HOUR_MAX);
      cfac_pkg::FLD_MIN:     write_value_o = cfac_pkg::step_wrap(
                               7'(item_i.cur_minutes), 7'd0, cfac_pkg::MIN_MAX);
      cfac_pkg::FLD_WEEKDAY: write_value_o = cfac_pkg::step_wrap(
                               7'(item_i.cur_weekday), cfac_pkg::WEEKDAY_MIN,
                               cfac_pkg::WEEKDAY_MAX);
      cfac_pkg::FLD_MONTH:   write_value_o = cfac_pkg::step_wrap(
                               7'(item_i.cur_month), cfac_pkg::MONTH_MIN,
                               cfac_pkg::MONTH_MAX);
      cfac_pkg::FLD_DATE:    write_value_o = cfac_pkg::step_wrap(
                               7'(item_i.cur_date), cfac_pkg::DATE_MIN,
                               cfac_pkg::month_days(item_i.cur_month, item_i.cur_year));
      default:               write_value_o = cfac_pkg::step_wrap(
                               item_i.cur_year, 7'd0, cfac_pkg::YEAR_MAX);
    endcase
  end

endmodule

@@ hw/rtl/cfac_panel.sv @@
// Button, adjust-mode and blink state, updated once per event; builds the result.
module cfac_panel (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  cfac_pkg::item_t   item_i,
  input  logic [15:0]       long_press_i,
  output cfac_pkg::result_t result_o
);

  logic [15:0] hold_q, hold_d;
  logic        wait_q, wait_d;
  logic        adj_q, adj_d;
  logic [2:0]  sel_q, sel_d;
  logic        blink_q, blink_d;
  logic [15:0] hold_inc;
  logic        wen;
  logic        clr;
  logic [6:0]  wval;

  cfac_wval u_wval (
    .field_select_i (sel_q),
    .item_i         (item_i),
    .write_value_o  (wval)
  );

  assign hold_inc = (hold_q != cfac_pkg::HOLD_MAX) ? hold_q + 16'd1 : hold_q;

  always_comb begin
    hold_d  = hold_q;
    wait_d  = wait_q;
    adj_d   = adj_q;
    sel_d   = sel_q;
    blink_d = blink_q;
    wen     = 1'b0;
    clr     = 1'b0;
    unique case (item_i.mode)
      cfac_pkg::MODE_BUTTON: begin
        if (item_i.adjust_pressed) begin
          if (!wait_q) begin
            hold_d = hold_inc;
            if (hold_inc > long_press_i) begin
              adj_d  = !adj_q;
              if (adj_q) sel_d = 3'(cfac_pkg::FLD_SEC);
              hold_d = 16'd0;
              wait_d = 1'b1;
            end
          end
        end else begin
          // release after a counted hold is a short press
          if (!wait_q && hold_q != 16'd0) begin
            if (adj_q) begin
              sel_d = (sel_q >= 3'(cfac_pkg::FLD_YEAR)) ? 3'(cfac_pkg::FLD_SEC)
                                                        : sel_q + 3'd1;
            end else begin
              clr = 1'b1;
            end
          end
          hold_d = 16'd0;
          wait_d = 1'b0;
        end
      end
      cfac_pkg::MODE_REFRESH: begin
        if (item_i.change_pressed) begin
          wen     = 1'b1;
          blink_d = 1'b0;
        end
      end
      cfac_pkg::MODE_BLINK: begin
        if (adj_q) blink_d = !blink_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o.write_enable  = wen;
    result_o.write_field   = wen ? sel_q : 3'd0;
    result_o.write_value   = wen ? wval : 7'd0;
    result_o.hidden_field  = (adj_d && blink_d) ? sel_d + 3'd1 : 3'd0;
    result_o.adjust_active = adj_d;
    result_o.clear_request = clr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= 16'd0;
      wait_q  <= 1'b0;
      adj_q   <= 1'b0;
      sel_q   <= 3'd0;
      blink_q <= 1'b1;
    end else if (advance_i) begin
      hold_q  <= hold_d;
      wait_q  <= wait_d;
      adj_q   <= adj_d;
      sel_q   <= sel_d;
      blink_q <= blink_d;
    end
  end

endmodule

@@ hw/rtl/clock_field_adjust_controller.sv @@
// Clock field adjust controller: event register, panel state logic, result register.
// An accepted event passes through the event register, then the result register.
// Throughput: one event per cycle while the result sink is ready; the panel state
// updates as an event moves from the event register into the result register.
// Reset (rst_ni low, asynchronous): both channels empty, hold count and flags
// cleared, field select 0, blink phase 1, long press threshold 1500.
module clock_field_adjust_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  cfac_item_if.sink          item_i,
  cfac_result_if.source      result_o
);

  cfac_pkg::item_t   item_q;
  logic              item_vld_q;
  cfac_pkg::result_t res_q, res_d;
  logic              res_vld_q;
  logic [15:0]       long_press_q;
  logic              advance;
  logic              item_acc;

  assign advance      = item_vld_q && (!res_vld_q || result_o.ready);
  assign item_i.ready = !item_vld_q || advance;
  assign item_acc     = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= cfac_pkg::LONG_PRESS_RESET;
    end else if (cfg_we_i) begin
      long_press_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (item_i.ready) begin
      item_vld_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      item_q.mode           <= cfac_pkg::mode_e'(item_i.mode);
      item_q.adjust_pressed <= item_i.adjust_pressed;
      item_q.change_pressed <= item_i.change_pressed;
      item_q.cur_seconds    <= item_i.cur_seconds;
      item_q.cur_minutes    <= item_i.cur_minutes;
      item_q.cur_hours      <= item_i.cur_hours;
      item_q.cur_weekday    <= item_i.cur_weekday;
      item_q.cur_date       <= item_i.cur_date;
      item_q.cur_month      <= item_i.cur_month;
      item_q.cur_year       <= item_i.cur_year;
    end
  end

  cfac_panel u_panel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .item_i       (item_q),
    .long_press_i (long_press_q),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign result_o.valid         = res_vld_q;
  assign result_o.write_enable  = res_q.write_enable;
  assign result_o.write_field   = res_q.write_field;
  assign result_o.write_value   = res_q.write_value;
  assign result_o.hidden_field  = res_q.hidden_field;
  assign result_o.adjust_active = res_q.adjust_active;
  assign result_o.clear_request = res_q.clear_request;

endmodule

@@ hw/rtl/cfac_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
module cfac_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       write_enable_i,
  input logic [2:0] write_field_i,
  input logic [6:0] write_value_i,
  input logic [2:0] hidden_field_i,
  input logic       adjust_active_i,
  input logic       clear_request_i
);

  // a stalled result beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !write_enable_i |-> write_field_i == 3'd0 && write_value_i == 7'd0)
    else $error("write payload set without write enable");

  // blanking only happens in adjust mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && hidden_field_i != 3'd0 |-> adjust_active_i)
    else $error("hidden field outside adjust mode");

  // a clear comes from a button tick outside adjust mode, never with a write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && clear_request_i |-> !adjust_active_i && !write_enable_i)
    else $error("clear request with adjust mode or write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && write_enable_i |-> write_field_i != 3'd7)
    else $error("write to nonexistent field");

endmodule

bind clock_field_adjust_controller cfac_checker u_cfac_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (result_o.valid),
  .res_ready_i     (result_o.ready),
  .write_enable_i  (result_o.write_enable),
  .write_field_i   (result_o.write_field),
  .write_value_i   (result_o.write_value),
  .hidden_field_i  (result_o.hidden_field),
  .adjust_active_i (result_o.adjust_active),
  .clear_request_i (result_o.clear_request)
);

@@ tb/clock_field_adjust_controller_tb.sv @@
// Self-checking testbench for the clock field adjust controller.
module clock_field_adjust_controller_tb;
  import cfac_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_STALL  = 400;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  cfac_item_if   evt_if ();
  cfac_result_if res_if ();

  clock_field_adjust_controller i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (evt_if),
    .result_o    (res_if)
  );

  // Panel model state
  logic [15:0] press_limit   = LONG_PRESS_RESET;
  logic [15:0] held_ticks    = '0;
  logic        await_release = 1'b0;
  logic        adjusting     = 1'b0;
  field_e      sel_field     = FLD_SEC;
  logic        blink_on      = 1'b1;

  item_t   panel_events[$];
  result_t panel_outcomes[$];

  int      mismatch_cnt = 0;
  int      quiet_cycles = 0;
  int      src_gap, src_calm = 0;
  int      sink_gap, sink_calm = 0;
  int      stall_asked = 0;
  int      stall_seen;
  item_t   taken_evt;
  result_t seen_beat, want_beat;

  always #5 clk = ~clk;

  function automatic result_t advance_panel(item_t ev);
    result_t    r;
    logic [6:0] v, lo, hi;
    r  = '0;
    v  = '0;
    lo = '0;
    hi = '0;
    case (ev.mode)
      MODE_BUTTON: begin
        if (ev.adjust_pressed) begin
          if (!await_release) begin
            if (held_ticks != HOLD_MAX) held_ticks = held_ticks + 16'd1;
            if (held_ticks > press_limit) begin
              adjusting = !adjusting;
              if (!adjusting) sel_field = FLD_SEC;
              held_ticks    = '0;
              await_release = 1'b1;
            end
          end
        end else begin
          // button released after a counted hold: short press
          if (!await_release && held_ticks != '0) begin
            if (adjusting) sel_field = (sel_field == FLD_YEAR) ? FLD_SEC : field_e'(sel_field + 3'd1);
            else r.clear_request = 1'b1;
          end
          held_ticks    = '0;
          await_release = 1'b0;
        end
      end
      MODE_REFRESH: begin
        if (ev.change_pressed) begin
          case (sel_field)
            FLD_SEC: ;  // seconds always go to zero
            FLD_HOUR: begin
              v  = {2'b0, ev.cur_hours};
              hi = HOUR_MAX;
            end
            FLD_MIN: begin
              v  = {1'b0, ev.cur_minutes};
              hi = MIN_MAX;
            end
            FLD_WEEKDAY: begin
              v  = {4'b0, ev.cur_weekday};
              lo = WEEKDAY_MIN;
              hi = WEEKDAY_MAX;
            end
            FLD_MONTH: begin
              v  = {3'b0, ev.cur_month};
              lo = MONTH_MIN;
              hi = MONTH_MAX;
            end
            FLD_DATE: begin
              v  = {2'b0, ev.cur_date};
              lo = DATE_MIN;
              case (ev.cur_month)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: hi = DAYS_LONG;
                4'd2: hi = (ev.cur_year[1:0] == 2'b00) ? DAYS_FEB_LP : DAYS_FEB;
                default: hi = DAYS_SHORT;
              endcase
            end
            default: begin
              v  = ev.cur_year;
              hi = YEAR_MAX;
            end
          endcase
          r.write_enable = 1'b1;
          r.write_field  = sel_field;
          r.write_value  = (v >= hi) ? lo : v + 7'd1;
          blink_on       = 1'b0;
        end
      end
      MODE_BLINK: begin
        if (adjusting) blink_on = !blink_on;
      end
      default: ;
    endcase
    r.hidden_field  = (adjusting && blink_on) ? sel_field + 3'd1 : 3'd0;
    r.adjust_active = adjusting;
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("we=%0d field=%0d value=%0d hidden=%0d adj=%0d clr=%0d",
                     r.write_enable, r.write_field, r.write_value, r.hidden_field,
                     r.adjust_active, r.clear_request);
  endfunction

  // Mostly short gaps, a few long ones, and occasional gap-free stretches.
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick(int unsigned lo, int unsigned hi);
    return ($urandom_range(0, 3) == 0) ? hi - $urandom_range(0, 3) : $urandom_range(lo, hi);
  endfunction

  function automatic item_t make_item(mode_e m);
    item_t       it;
    logic [63:0] bits;
    if ($urandom_range(0, 4) == 0) begin
      bits = {$urandom, $urandom};
      it   = bits[39:0];
    end else begin
      it.adjust_pressed = 1'($urandom);
      it.change_pressed = 1'($urandom);
      it.cur_seconds    = 6'(pick(0, 59));
      it.cur_minutes    = 6'(pick(0, 59));
      it.cur_hours      = 5'(pick(0, 23));
      it.cur_weekday    = 3'(pick(1, 7));
      it.cur_date       = 5'(pick(1, 31));
      it.cur_month      = ($urandom_range(0, 3) == 0) ? 4'd2 : 4'(pick(1, 12));
      it.cur_year       = 7'(pick(0, 99));
    end
    it.mode = m;
    return it;
  endfunction

  task automatic queue_tick(logic adj);
    item_t it;
    it = make_item(MODE_BUTTON);
    it.adjust_pressed = adj;
    panel_events.push_back(it);
  endtask

  task automatic queue_refresh(logic chg);
    item_t it;
    it = make_item(MODE_REFRESH);
    it.change_pressed = chg;
    panel_events.push_back(it);
  endtask

  // len held ticks then one release tick; mix lets refresh/blink beats slip in
  task automatic queue_press(int len, bit mix);
    for (int i = 0; i < len; i++) begin
      if (mix && $urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 1) == 0) queue_refresh(1'($urandom));
        else panel_events.push_back(make_item(MODE_BLINK));
      end
      queue_tick(1'b1);
    end
    queue_tick(1'b0);
  endtask

  task automatic queue_random(int n, int unsigned thr);
    int left;
    int r;
    int len;
    left = n;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        len = $urandom_range(1, (thr > 40) ? 40 : thr);
        queue_press(len, 1'b1);
        left -= len + 1;
      end else if (r < 47 && thr <= 64) begin
        len = thr + 1 + $urandom_range(0, 4);
        queue_press(len, 1'b1);
        left -= len + 1;
      end else begin
        if (r < 75) queue_refresh(($urandom_range(0, 9) < 7) ? 1'b1 : 1'b0);
        else if (r < 88) panel_events.push_back(make_item(MODE_BLINK));
        else if (r < 92) panel_events.push_back(make_item(MODE_NONE));
        else panel_events.push_back(make_item(mode_e'($urandom_range(0, 3))));
        left -= 1;
      end
    end
  endtask

  task automatic drain();
    while (panel_events.size() != 0 || evt_if.valid || panel_outcomes.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_threshold(logic [15:0] val);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we      <= 1'b0;
    press_limit  = val;
  endtask

  // Event driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      evt_if.valid <= 1'b0;
      {evt_if.mode, evt_if.adjust_pressed, evt_if.change_pressed, evt_if.cur_seconds,
       evt_if.cur_minutes, evt_if.cur_hours, evt_if.cur_weekday, evt_if.cur_date,
       evt_if.cur_month, evt_if.cur_year} <= '0;
      src_gap <= 0;
    end else if (!evt_if.valid || evt_if.ready) begin
      if (src_gap > 0) begin
        evt_if.valid <= 1'b0;
        src_gap      <= src_gap - 1;
      end else if (panel_events.size() != 0) begin
        {evt_if.mode, evt_if.adjust_pressed, evt_if.change_pressed, evt_if.cur_seconds,
         evt_if.cur_minutes, evt_if.cur_hours, evt_if.cur_weekday, evt_if.cur_date,
         evt_if.cur_month, evt_if.cur_year} <= panel_events.pop_front();
        evt_if.valid <= 1'b1;
        src_gap      <= idle_len(src_calm);
      end else begin
        evt_if.valid <= 1'b0;
      end
    end
  end

  // Result sink backpressure
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      sink_gap     <= 0;
      stall_seen   <= 0;
    end else if (stall_seen != stall_asked) begin
      res_if.ready <= 1'b0;
      sink_gap     <= LONG_STALL;
      stall_seen   <= stall_asked;
    end else if (sink_gap > 0) begin
      res_if.ready <= 1'b0;
      sink_gap     <= sink_gap - 1;
    end else begin
      res_if.ready <= 1'b1;
      sink_gap     <= idle_len(sink_calm);
    end
  end

  // Monitor: predict on each accepted event, check each accepted result beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (evt_if.valid && evt_if.ready) begin
        taken_evt = {evt_if.mode, evt_if.adjust_pressed, evt_if.change_pressed,
                     evt_if.cur_seconds, evt_if.cur_minutes, evt_if.cur_hours,
                     evt_if.cur_weekday, evt_if.cur_date, evt_if.cur_month, evt_if.cur_year};
        panel_outcomes.push_back(advance_panel(taken_evt));
      end
      if (res_if.valid && res_if.ready) begin
        seen_beat = {res_if.write_enable, res_if.write_field, res_if.write_value,
                     res_if.hidden_field, res_if.adjust_active, res_if.clear_request};
        if (panel_outcomes.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result beat with nothing expected: %s", $realtime, show(seen_beat));
        end else begin
          want_beat = panel_outcomes.pop_front();
          if (seen_beat !== want_beat) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: result mismatch: got %s, expected %s", $realtime,
                       show(seen_beat), show(want_beat));
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("clock_field_adjust_controller test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    item_t       ev;
    int unsigned thr;
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // threshold at its reset value: idle-mode behavior
    panel_events.push_back(make_item(MODE_BLINK));  // blink timer stopped
    panel_events.push_back(make_item(MODE_NONE));
    queue_refresh(1'b1);                            // change outside adjust still writes
    queue_refresh(1'b0);
    queue_press(1, 1'b0);                           // short press asks for a clear

    set_threshold(16'd1);
    queue_press(3, 1'b0);                           // toggle on, extra tick ignored
    panel_events.push_back(make_item(MODE_BLINK));
    queue_press(1, 1'b0);
    ev = make_item(MODE_REFRESH);
    ev.change_pressed = 1'b1;
    ev.cur_hours      = 5'd23;
    panel_events.push_back(ev);
    queue_press(1, 1'b0);
    ev = make_item(MODE_REFRESH);
    ev.change_pressed = 1'b1;
    ev.cur_minutes    = 6'd63;
    panel_events.push_back(ev);
    queue_press(1, 1'b0);
    ev = make_item(MODE_REFRESH);
    ev.change_pressed = 1'b1;
    ev.cur_weekday    = 3'd0;
    panel_events.push_back(ev);
    queue_press(1, 1'b0);
    ev = make_item(MODE_REFRESH);
    ev.change_pressed = 1'b1;
    ev.cur_month      = 4'd15;
    panel_events.push_back(ev);
    queue_press(1, 1'b0);
    ev = make_item(MODE_REFRESH);
    ev.change_pressed = 1'b1;
    ev.cur_month      = 4'd2;
    ev.cur_year       = 7'd4;
    ev.cur_date       = 5'd29;                      // leap February end
    panel_events.push_back(ev);
    queue_press(1, 1'b0);
    ev = make_item(MODE_REFRESH);
    ev.change_pressed = 1'b1;
    ev.cur_year       = 7'd127;
    panel_events.push_back(ev);

    drain();
    queue_random(250, 1);
    @(posedge clk);
    stall_asked <= stall_asked + 1;                 // sink holds off, input backs up

    set_threshold(16'd4);
    queue_random(250, 4);
    for (int p = 0; p < 2; p++) begin
      thr = $urandom_range(2, 12);
      set_threshold(16'(thr));
      queue_random(250, thr);
    end

    // top threshold: no hold toggles
    set_threshold(16'hFFFF);
    queue_press(40, 1'b0);
    queue_random(100, 65535);

    set_threshold(LONG_PRESS_RESET);
    queue_random(100, LONG_PRESS_RESET);

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && panel_outcomes.size() == 0) begin
      $display("clock_field_adjust_controller test passed");
    end else begin
      $display("clock_field_adjust_controller test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/cfac_pkg.sv
hw/rtl/cfac_if.sv
hw/rtl/cfac_wval.sv
hw/rtl/cfac_panel.sv
hw/rtl/clock_field_adjust_controller.sv
hw/rtl/cfac_checker.sv
tb/clock_field_adjust_controller_tb.sv
